/* design/prq_pkg.sv */
// ----------------------------------------------------------------------------
// prq_pkg: shared definitions for the page replacement order queue
// Request and status codes and the control bundle that drives the cell row.
// ----------------------------------------------------------------------------
package prq_pkg;

    typedef logic [2:0] func_t;
    typedef logic [1:0] status_t;

    localparam func_t FN_PUSH   = 3'd0;
    localparam func_t FN_POP    = 3'd1;
    localparam func_t FN_FIND   = 3'd2;
    localparam func_t FN_MOVE   = 3'd3;
    localparam func_t FN_REMOVE = 3'd4;
    localparam func_t FN_SIZE   = 3'd5;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_EMPTY   = 2'd1;
    localparam status_t ST_FULL    = 2'd2;
    localparam status_t ST_MISSING = 2'd3;

    typedef struct packed {
        logic cmp_en;
        logic pre_en;
        logic shift_en;
        logic shift_all;
        logic wr_en;
    } cell_ctl_t;

endpackage

/* design/prq_if.sv */
// ----------------------------------------------------------------------------
// prq_if: request and response channels of the page replacement order queue
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface prq_req_if #(
    parameter int PAGE_BITS = 12
);
    logic                 valid;
    logic                 ready;
    prq_pkg::func_t       func;
    logic [PAGE_BITS-1:0] page;

    modport source (output valid, output func, output page, input ready);
    modport sink   (input valid, input func, input page, output ready);
endinterface

interface prq_rsp_if #(
    parameter int PAGE_BITS = 12,
    parameter int POS_BITS  = 6,
    parameter int OCC_BITS  = 7
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] out_page;
    logic                 found;
    logic [POS_BITS-1:0]  position;
    logic [OCC_BITS-1:0]  occupancy;
    prq_pkg::status_t     status;

    modport source (output valid, output out_page, output found, output position,
                    output occupancy, output status, input ready);
    modport sink   (input valid, input out_page, input found, input position,
                    input occupancy, input status, output ready);
endinterface

/* design/page_replacement_order_queue.sv */
// ----------------------------------------------------------------------------
// page_replacement_order_queue: resident pages in replacement order
// A row of DEPTH cells keeps the pages from oldest (head) to newest (tail)
// and serves push, pop, find, move-to-tail, remove and size requests.
//
//   Channel | Dir | Payload
//   --------+-----+---------------------------------------------------
//   req     | in  | func, page
//   rsp     | out | out_page, found, position, occupancy, status
//
// Every request passes through capture, compare in all cells, first-match
// prefix along the row, then update of the row and the response register.
// Reset clears the count and the control state; the slots need no clearing.
// A request is taken while the previous response still waits; the update
// cycle holds until the response register is free.
// ----------------------------------------------------------------------------
module page_replacement_order_queue #(
    parameter int DEPTH     = 64,
    parameter int PAGE_BITS = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    prq_req_if.sink       req,
    prq_rsp_if.source     rsp
);
    import prq_pkg::*;

    localparam int POS_BITS = $clog2(DEPTH);
    localparam int OCC_BITS = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_PRE  = 2'd2;
    localparam logic [1:0] S_EXEC = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    func_t                func_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [OCC_BITS-1:0]  count_reg;
    logic [OCC_BITS-1:0]  count_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [PAGE_BITS-1:0] out_page_reg;
    logic                 out_found_reg;
    logic [POS_BITS-1:0]  out_pos_reg;
    logic [OCC_BITS-1:0]  out_occ_reg;
    status_t              out_status_reg;

    logic                 fire;
    cell_ctl_t            ctl;
    logic                 shift_en;
    logic                 shift_all;
    logic                 wr_en;
    logic [OCC_BITS-1:0]  wr_idx;
    logic [PAGE_BITS-1:0] res_page;
    logic                 res_found;
    logic [POS_BITS-1:0]  res_pos;
    status_t              res_status;
    logic [POS_BITS-1:0]  hot_pos;
    logic                 found_any;

    logic [PAGE_BITS-1:0] slot_page [DEPTH];
    logic [DEPTH-1:0]     pre_c;
    logic [DEPTH-1:0]     pre_q;
    logic [DEPTH-1:0]     hot;
    logic [DEPTH-1:0]     live;
    logic [DEPTH-1:0]     wr_sel;

    assign req.ready = (state_reg == S_IDLE);
    assign fire      = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);
    assign found_any = pre_q[DEPTH-1];

    always_comb
    begin
        hot_pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hot[i])
            begin
                hot_pos = hot_pos | POS_BITS'(i);
            end
        end
    end

    always_comb
    begin
        shift_en   = 1'b0;
        shift_all  = 1'b0;
        wr_en      = 1'b0;
        wr_idx     = count_reg;
        count_next = count_reg;
        res_page   = page_reg;
        res_found  = 1'b0;
        res_pos    = '0;
        res_status = ST_OK;
        case (func_reg)
            FN_PUSH:
            begin
                if (count_reg == OCC_BITS'(DEPTH))
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + OCC_BITS'(1);
                end
            end
            FN_POP:
            begin
                if (count_reg == '0)
                begin
                    res_status = ST_EMPTY;
                    res_page   = '0;
                end
                else
                begin
                    res_page   = slot_page[0];
                    res_found  = 1'b1;
                    shift_en   = 1'b1;
                    shift_all  = 1'b1;
                    count_next = count_reg - OCC_BITS'(1);
                end
            end
            FN_FIND, FN_MOVE, FN_REMOVE:
            begin
                if (!found_any)
                begin
                    res_status = ST_MISSING;
                end
                else
                begin
                    res_found = 1'b1;
                    res_pos   = hot_pos;
                    if (func_reg == FN_MOVE)
                    begin
                        shift_en = 1'b1;
                        wr_en    = 1'b1;
                        wr_idx   = count_reg - OCC_BITS'(1);
                    end
                    else if (func_reg == FN_REMOVE)
                    begin
                        shift_en   = 1'b1;
                        count_next = count_reg - OCC_BITS'(1);
                    end
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    assign ctl.cmp_en    = (state_reg == S_CMP);
    assign ctl.pre_en    = (state_reg == S_PRE);
    assign ctl.shift_en  = fire && shift_en;
    assign ctl.shift_all = shift_all;
    assign ctl.wr_en     = fire && wr_en;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        assign live[g]   = (OCC_BITS'(g) < count_reg);
        assign wr_sel[g] = (OCC_BITS'(g) == wr_idx);

        prq_cell #(
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .req_page   (page_reg),
            .live       (live[g]),
            .wr_sel     (wr_sel[g]),
            .next_page  ((g == DEPTH - 1) ? slot_page[g] : slot_page[(g + 1) % DEPTH]),
            .prev_pre_c ((g == 0) ? 1'b0 : pre_c[(g + DEPTH - 1) % DEPTH]),
            .prev_pre_q ((g == 0) ? 1'b0 : pre_q[(g + DEPTH - 1) % DEPTH]),
            .slot_page  (slot_page[g]),
            .pre_c      (pre_c[g]),
            .pre_q      (pre_q[g]),
            .hot        (hot[g])
        );
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = req.valid ? S_CMP : S_IDLE;
            S_CMP:   state_next = S_PRE;
            S_PRE:   state_next = S_EXEC;
            S_EXEC:  state_next = fire ? S_IDLE : S_EXEC;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            func_reg <= req.func;
            page_reg <= req.page;
        end
        if (fire)
        begin
            out_page_reg   <= res_page;
            out_found_reg  <= res_found;
            out_pos_reg    <= res_pos;
            out_occ_reg    <= count_next;
            out_status_reg <= res_status;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.out_page  = out_page_reg;
    assign rsp.found     = out_found_reg;
    assign rsp.position  = out_pos_reg;
    assign rsp.occupancy = out_occ_reg;
    assign rsp.status    = out_status_reg;

endmodule

/* design/prq_cell.sv */
// ----------------------------------------------------------------------------
// prq_cell: one slot of the replacement order row
// Holds one page, compares it against the request, carries the match prefix
// along the row and shifts toward the head when an entry is taken out.
// ----------------------------------------------------------------------------
module prq_cell #(
    parameter int PAGE_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  prq_pkg::cell_ctl_t   ctl,
    input  logic [PAGE_BITS-1:0] req_page,
    input  logic                 live,
    input  logic                 wr_sel,
    input  logic [PAGE_BITS-1:0] next_page,
    input  logic                 prev_pre_c,
    input  logic                 prev_pre_q,
    output logic [PAGE_BITS-1:0] slot_page,
    output logic                 pre_c,
    output logic                 pre_q,
    output logic                 hot
);
    import prq_pkg::*;

    logic [PAGE_BITS-1:0] slot_reg;
    logic [PAGE_BITS-1:0] slot_next;
    logic                 match_reg;
    logic                 match_next;
    logic                 pre_reg;
    logic                 pre_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctl.wr_en && wr_sel)
        begin
            slot_next = req_page;
        end
        else if (ctl.shift_en && (pre_reg || ctl.shift_all))
        begin
            slot_next = next_page;
        end
    end

    assign match_next = ctl.cmp_en ? (live && (slot_reg == req_page)) : match_reg;
    assign pre_c      = match_reg | prev_pre_c;
    assign pre_next   = ctl.pre_en ? pre_c : pre_reg;

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            pre_reg   <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            pre_reg   <= pre_next;
        end
    end

    assign slot_page = slot_reg;
    assign pre_q     = pre_reg;
    assign hot       = pre_reg & ~prev_pre_q;

endmodule

/* design/prq_checker.sv */
// ----------------------------------------------------------------------------
// prq_checker: port-level checks for the page replacement order queue
// Watches the request and response channels and flags inconsistent results and requests taken while busy.
// ----------------------------------------------------------------------------
module prq_checker #(
    parameter int DEPTH     = 64,
    parameter int PAGE_BITS = 12
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic [PAGE_BITS-1:0]         rsp_out_page,
    input logic                         rsp_found,
    input logic [$clog2(DEPTH+1)-1:0]   rsp_occupancy,
    input prq_pkg::status_t             rsp_status
);
    import prq_pkg::*;

    localparam int OCC_BITS = $clog2(DEPTH + 1);

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_occupancy <= OCC_BITS'(DEPTH)))
        else $error("occupancy above depth");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == ST_FULL)) |-> (rsp_occupancy == OCC_BITS'(DEPTH)))
        else $error("full status with free slots");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == ST_EMPTY)) |->
        ((rsp_occupancy == '0) && (rsp_out_page == '0) && !rsp_found))
        else $error("empty pop result inconsistent");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_found) |-> (rsp_status == ST_OK))
        else $error("found with error status");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while busy");

endmodule

bind page_replacement_order_queue prq_checker #(
    .DEPTH     (DEPTH),
    .PAGE_BITS (PAGE_BITS)
) u_prq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_out_page  (rsp.out_page),
    .rsp_found     (rsp.found),
    .rsp_occupancy (rsp.occupancy),
    .rsp_status    (rsp.status)
);
